/* sv/nfc_pkg.sv */
`default_nettype none
package nfc_pkg;

  localparam int FLASH_ADDR_BITS_DEF = 32;

  // apb: one 32-bit register at byte address 0, paddr[2] selects the word
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-3:0] CFG_IDX_ROM_TYPE = '0;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [3:0] REG_CONTROL   = 4'd0;
  localparam logic [3:0] REG_COMMAND   = 4'd1;
  localparam logic [3:0] REG_ADDR_LOW  = 4'd2;
  localparam logic [3:0] REG_ADDR_HIGH = 4'd3;
  localparam logic [3:0] REG_DATA      = 4'd4;
  localparam logic [3:0] REG_TYPE      = 4'd6;

  localparam logic [15:0] CMD_READ0      = 16'h0000;
  localparam logic [15:0] CMD_READ1      = 16'h0001;
  localparam logic [15:0] CMD_READ_SPARE = 16'h0050;
  localparam logic [15:0] CMD_IDENT      = 16'h0090;

  localparam logic [3:0] TYPE_SHIFT4 = 4'd7;
  localparam logic [3:0] TYPE_SHIFT5 = 4'd11;

  localparam logic [15:0] CTRL_READY  = 16'h8000;
  localparam int          CTRL_DOUBLE = 14;
  localparam logic [15:0] RDATA_NONE  = 16'hFFFF;

  typedef struct packed {
    logic        op;
    logic [3:0]  reg_offset;
    logic [15:0] wdata;
  } in_beat_t;

  typedef struct packed {
    logic [15:0] rdata;
    logic        flash_req;
    logic [31:0] flash_addr;
  } out_beat_t;

  // register values that feed the flash address calculation
  typedef struct packed {
    logic [15:0] addr_high;
    logic [15:0] addr_low;
    logic        dbl;
    logic [3:0]  flash_type;
    logic [15:0] command;
  } addr_src_t;

  function automatic logic [7:0] ident_byte(input logic [1:0] rom_type,
                                            input logic [31:0] idx);
    logic [7:0] b;
    b = 8'h00;
    if (rom_type == 2'd0) begin
      b = (idx == 32'd0) ? 8'hC2 : 8'h76;
    end else if (rom_type == 2'd1) begin
      if (idx == 32'd0) b = 8'hAD;
      else if (idx == 32'd1) b = 8'h76;
    end else begin
      if (idx == 32'd0) b = 8'hAD;
      else if (idx == 32'd1) b = 8'hF1;
      else if (idx == 32'd2) b = 8'h80;
      else if (idx == 32'd3) b = 8'h1D;
    end
    return b;
  endfunction

endpackage
`default_nettype wire

/* sv/nfc_cfg.sv */
`default_nettype none
module nfc_cfg import nfc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output logic      [1:0]            rom_type
);

  logic sel_rom_type;

  assign pready       = 1'b1;
  assign sel_rom_type = (paddr[CFG_ADDR_W-1:2] == CFG_IDX_ROM_TYPE);
  assign prdata       = sel_rom_type ? {30'd0, rom_type} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_type <= 2'd0;
    end else if (psel && penable && pwrite && pready && sel_rom_type) begin
      rom_type <= pwdata[1:0];
    end
  end

endmodule
`default_nettype wire

/* sv/nfc_addr.sv */
`default_nettype none
module nfc_addr import nfc_pkg::*; #(
  parameter int FLASH_ADDR_BITS = FLASH_ADDR_BITS_DEF
) (
  input  wire addr_src_t                  src,
  output logic [FLASH_ADDR_BITS-1:0]      eff_addr
);

  logic [31:0] a;
  logic [31:0] page;
  logic [31:0] off;
  logic [31:0] sum;
  logic [31:0] shifted;

  always_comb begin
    a = {src.addr_high, src.addr_low};
    if (src.dbl) a = a << 1;
    page = (src.flash_type != 4'd0) ? a : (a >> 8);
    priority if (src.command == CMD_READ1) begin
      off = 32'd256;
    end else if (src.command == CMD_READ_SPARE) begin
      off = 32'd512;
    end else begin
      off = 32'd0;
    end
    // page * 528 as two shifted terms
    sum = (page << 9) + (page << 4) + off;
    priority if (src.flash_type == TYPE_SHIFT4) begin
      shifted = sum << 4;
    end else if (src.flash_type == TYPE_SHIFT5) begin
      shifted = sum << 5;
    end else begin
      shifted = sum;
    end
    eff_addr = FLASH_ADDR_BITS'(shifted);
  end

endmodule
`default_nettype wire

/* sv/nfc_core.sv */
`default_nettype none
module nfc_core import nfc_pkg::*; #(
  parameter int FLASH_ADDR_BITS = FLASH_ADDR_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [1:0] rom_type,
  input  wire logic       acc_valid,
  output logic            acc_stall,
  input  wire in_beat_t   acc,
  output logic            res_valid,
  input  wire logic       res_stall,
  output out_beat_t       res
);

  in_beat_t  in_q;
  logic      in_full;
  logic      advance;

  logic [15:0]                command_reg, command_reg_next;
  logic [15:0]                addr_low_reg, addr_low_reg_next;
  logic [15:0]                addr_high_reg, addr_high_reg_next;
  logic [15:0]                control_reg, control_reg_next;
  logic [3:0]                 type_reg, type_reg_next;
  logic [FLASH_ADDR_BITS-1:0] effective_addr, effective_addr_next;
  logic [31:0]                byte_counter, byte_counter_next;

  addr_src_t                  src;
  logic [FLASH_ADDR_BITS-1:0] calc_addr;
  logic [FLASH_ADDR_BITS-1:0] sum_addr;
  out_beat_t                  res_next;

  assign advance   = in_full && (!res_valid || !res_stall);
  assign acc_stall = in_full && !advance;

  // recompute sees the register values including this beat's write
  assign src = '{addr_high:  addr_high_reg_next,
                 addr_low:   addr_low_reg_next,
                 dbl:        control_reg_next[CTRL_DOUBLE],
                 flash_type: type_reg_next,
                 command:    command_reg_next};

  nfc_addr #(.FLASH_ADDR_BITS(FLASH_ADDR_BITS)) u_addr (
    .src      (src),
    .eff_addr (calc_addr)
  );

  assign sum_addr = effective_addr + FLASH_ADDR_BITS'(byte_counter);

  always_comb begin
    command_reg_next    = command_reg;
    addr_low_reg_next   = addr_low_reg;
    addr_high_reg_next  = addr_high_reg;
    control_reg_next    = control_reg;
    type_reg_next       = type_reg;
    effective_addr_next = effective_addr;
    byte_counter_next   = byte_counter;
    res_next            = '{rdata: 16'd0, flash_req: 1'b0, flash_addr: 32'd0};

    if (in_q.op == OP_WRITE) begin
      unique case (in_q.reg_offset)
        REG_CONTROL: control_reg_next = in_q.wdata;
        REG_COMMAND: command_reg_next = in_q.wdata;
        REG_ADDR_LOW: begin
          addr_low_reg_next = in_q.wdata;
          byte_counter_next = 32'd0;
        end
        REG_ADDR_HIGH: begin
          addr_high_reg_next = in_q.wdata;
          byte_counter_next  = 32'd0;
        end
        REG_TYPE: begin
          type_reg_next     = in_q.wdata[3:0];
          byte_counter_next = 32'd0;
        end
        default: ;
      endcase
      if (in_q.reg_offset == REG_ADDR_HIGH || in_q.reg_offset == REG_TYPE) begin
        effective_addr_next = calc_addr;
      end
    end else begin
      if (in_q.reg_offset == REG_CONTROL) begin
        res_next.rdata = control_reg | CTRL_READY;
      end else if (in_q.reg_offset == REG_DATA) begin
        priority if (command_reg == CMD_IDENT) begin
          res_next.rdata    = {8'd0, ident_byte(rom_type, byte_counter)};
          byte_counter_next = byte_counter + 32'd1;
        end else if (command_reg == CMD_READ0 || command_reg == CMD_READ1 ||
                     command_reg == CMD_READ_SPARE) begin
          res_next.flash_req  = 1'b1;
          res_next.flash_addr = 32'(sum_addr);
          byte_counter_next   = byte_counter + 32'd1;
        end else begin
          res_next.rdata = RDATA_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full        <= 1'b0;
      res_valid      <= 1'b0;
      command_reg    <= '0;
      addr_low_reg   <= '0;
      addr_high_reg  <= '0;
      control_reg    <= '0;
      type_reg       <= '0;
      effective_addr <= '0;
      byte_counter   <= '0;
    end else begin
      if (acc_valid && !acc_stall) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end
      if (advance) begin
        res_valid      <= 1'b1;
        command_reg    <= command_reg_next;
        addr_low_reg   <= addr_low_reg_next;
        addr_high_reg  <= addr_high_reg_next;
        control_reg    <= control_reg_next;
        type_reg       <= type_reg_next;
        effective_addr <= effective_addr_next;
        byte_counter   <= byte_counter_next;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc_valid && !acc_stall) in_q <= acc;
    if (advance) res <= res_next;
  end

endmodule
`default_nettype wire

/* sv/nand_flash_controller_regs.sv */
// an accepted beat moves from the input register to the result register and onto
// res once res_stall is low or res holds nothing; throughput: one beat per cycle
// while res_stall is low, limited by the single input and result registers
// reset: synchronous active-high rst clears all controller registers, the byte
// counter, the effective address, rom_type and both valid flags
`default_nettype none
module nand_flash_controller_regs import nfc_pkg::*; #(
  parameter int FLASH_ADDR_BITS = FLASH_ADDR_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  input  wire logic                  acc_valid,
  output logic                       acc_stall,
  input  wire in_beat_t              acc,
  output logic                       res_valid,
  input  wire logic                  res_stall,
  output out_beat_t                  res
);

  logic [1:0] rom_type;

  nfc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .rom_type (rom_type)
  );

  nfc_core #(.FLASH_ADDR_BITS(FLASH_ADDR_BITS)) u_core (
    .clk       (clk),
    .rst       (rst),
    .rom_type  (rom_type),
    .acc_valid (acc_valid),
    .acc_stall (acc_stall),
    .acc       (acc),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import nfc_pkg::*;

  localparam int FLASH_ADDR_BITS = FLASH_ADDR_BITS_DEF;
  localparam logic [31:0] ADDR_MASK = 32'hFFFF_FFFF >> (32 - FLASH_ADDR_BITS);
  localparam logic [15:0] CMD_STATUS = 16'h0070;
  localparam logic [3:0] REG_DMA_CTRL = 4'd5;
  localparam logic [3:0] REG_ECC_LO = 4'd14;
  localparam logic [3:0] REG_ECC_HI = 4'd15;
  localparam int PHASE_ITEMS = 290;
  localparam int HOLD_CYCLES = 80;

  class flash_regs_scoreboard;
    logic [1:0] rom_type;
    logic [15:0] command;
    logic [15:0] addr_low;
    logic [15:0] addr_high;
    logic [15:0] control;
    logic [3:0] flash_type;
    logic [31:0] eff_addr;
    logic [31:0] byte_count;
    out_beat_t expected_q[$];
    int errors;

    function new();
      rom_type = '0;
      command = '0;
      addr_low = '0;
      addr_high = '0;
      control = '0;
      flash_type = '0;
      eff_addr = '0;
      byte_count = '0;
      errors = 0;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    function void refresh_eff_addr();
      logic [31:0] a;
      logic [31:0] page;
      logic [31:0] off;
      int unsigned sh;
      sh = (flash_type == TYPE_SHIFT4) ? 4 : (flash_type == TYPE_SHIFT5) ? 5 : 0;
      off = (command == CMD_READ1) ? 32'd256 : (command == CMD_READ_SPARE) ? 32'd512 : 32'd0;
      a = {addr_high, addr_low};
      if (control[CTRL_DOUBLE]) a = a << 1;
      // type zero addresses whole pages of 256 bytes
      page = (flash_type != 4'd0) ? a : (a >> 8);
      eff_addr = ((page * 32'd528 + off) << sh) & ADDR_MASK;
    endfunction

    function logic [7:0] ident_at(input logic [31:0] idx);
      logic [7:0] b;
      b = 8'h00;
      if (rom_type == 2'd0) begin
        b = (idx == 32'd0) ? 8'hC2 : 8'h76;
      end else if (rom_type == 2'd1) begin
        if (idx == 32'd0) b = 8'hAD;
        else if (idx == 32'd1) b = 8'h76;
      end else begin
        case (idx)
          32'd0: b = 8'hAD;
          32'd1: b = 8'hF1;
          32'd2: b = 8'h80;
          32'd3: b = 8'h1D;
          default: b = 8'h00;
        endcase
      end
      return b;
    endfunction

    function void note_access(input in_beat_t b);
      out_beat_t e;
      e = '0;
      if (b.op == OP_WRITE) begin
        case (b.reg_offset)
          REG_CONTROL: control = b.wdata;
          REG_COMMAND: command = b.wdata;
          REG_ADDR_LOW: begin
            addr_low = b.wdata;
            byte_count = '0;
          end
          REG_ADDR_HIGH: begin
            addr_high = b.wdata;
            refresh_eff_addr();
            byte_count = '0;
          end
          REG_TYPE: begin
            flash_type = b.wdata[3:0];
            refresh_eff_addr();
            byte_count = '0;
          end
          default: ;
        endcase
      end else if (b.reg_offset == REG_CONTROL) begin
        e.rdata = control | CTRL_READY;
      end else if (b.reg_offset == REG_DATA) begin
        if (command == CMD_IDENT) begin
          e.rdata = {8'h00, ident_at(byte_count)};
          byte_count = byte_count + 32'd1;
        end else if (command == CMD_READ0 || command == CMD_READ1 ||
                     command == CMD_READ_SPARE) begin
          e.flash_req = 1'b1;
          e.flash_addr = (eff_addr + byte_count) & ADDR_MASK;
          byte_count = byte_count + 32'd1;
        end else begin
          e.rdata = RDATA_NONE;
        end
      end
      expected_q.push_back(e);
    endfunction

    task check_result(input out_beat_t got);
      out_beat_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result beat %h with nothing expected", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.rdata !== want.rdata)
        report($sformatf("rdata %h, expected %h", got.rdata, want.rdata));
      if (got.flash_req !== want.flash_req)
        report($sformatf("flash_req %b, expected %b", got.flash_req, want.flash_req));
      if (got.flash_addr !== want.flash_addr)
        report($sformatf("flash_addr %h, expected %h", got.flash_addr, want.flash_addr));
    endtask

    task check_leftover();
      if (expected_q.size() != 0)
        report($sformatf("%0d result beats never arrived", expected_q.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  logic acc_valid;
  logic acc_stall;
  in_beat_t acc;
  logic res_valid;
  logic res_stall;
  out_beat_t res;

  flash_regs_scoreboard sb = new();
  bit hold_request = 1'b0;
  int burst_left = 0;
  int item_count = 0;
  int stall_mode = 0;
  logic [1:0] stall_tick = '0;

  nand_flash_controller_regs #(.FLASH_ADDR_BITS(FLASH_ADDR_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .acc_valid(acc_valid),
    .acc_stall(acc_stall),
    .acc(acc),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (acc_valid && !acc_stall) sb.note_access(acc);
      if (res_valid && !res_stall) sb.check_result(res);
    end
  end

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        res_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        res_stall = 1'b0;
      end else begin
        if ($urandom_range(0, 49) == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
          0: res_stall = 1'b0;
          1: res_stall = ($urandom_range(0, 3) == 0);
          2: res_stall = ($urandom_range(0, 3) != 0);
          default: begin
            res_stall = stall_tick[1];
            stall_tick = stall_tick + 2'd1;
          end
        endcase
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task send(input logic op, input logic [3:0] off, input logic [15:0] wd);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
      if (gap > 0) begin
        acc_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    acc_valid = 1'b1;
    acc.op = op;
    acc.reg_offset = off;
    acc.wdata = wd;
    do @(posedge clk); while (acc_stall);
    if (!(op == OP_WRITE && !(off inside {REG_CONTROL, REG_COMMAND, REG_ADDR_LOW,
                                           REG_ADDR_HIGH, REG_TYPE})))
      item_count++;
  endtask

  task wait_drained();
    @(negedge clk);
    acc_valid = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task cfg_write(input logic [1:0] val);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {CFG_IDX_ROM_TYPE, 2'b00};
    pwdata = {30'd0, val};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.rom_type = val;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task read_data_run(input int n);
    repeat (n) send(OP_READ, REG_DATA, rand_word());
  endtask

  task ident_sequence();
    send(OP_WRITE, REG_COMMAND, CMD_IDENT);
    if ($urandom_range(0, 2) == 0) send(OP_WRITE, REG_ADDR_LOW, rand_word());
    read_data_run($urandom_range(1, 7));
  endtask

  task page_sequence();
    logic [15:0] cmd;
    logic [15:0] ctl;
    case ($urandom_range(0, 2))
      0: cmd = CMD_READ0;
      1: cmd = CMD_READ1;
      default: cmd = CMD_READ_SPARE;
    endcase
    if ($urandom_range(0, 2) == 0) begin
      ctl = rand_word();
      send(OP_WRITE, REG_CONTROL, ctl);
    end
    send(OP_WRITE, REG_COMMAND, cmd);
    send(OP_WRITE, REG_ADDR_LOW, rand_word());
    send(OP_WRITE, REG_ADDR_HIGH, rand_word());
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0: send(OP_WRITE, REG_TYPE, {rand_word() & 16'hFFF0});
        1: send(OP_WRITE, REG_TYPE, {rand_word() & 16'hFFF0} | TYPE_SHIFT4);
        2: send(OP_WRITE, REG_TYPE, {rand_word() & 16'hFFF0} | TYPE_SHIFT5);
        default: send(OP_WRITE, REG_TYPE, rand_word());
      endcase
    end
    if ($urandom_range(0, 3) == 0) send(OP_READ, REG_CONTROL, rand_word());
    read_data_run($urandom_range(1, 10));
  endtask

  task noise_sequence();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 4) == 0)
        send(OP_WRITE, REG_COMMAND, ($urandom_range(0, 1) == 0) ? CMD_STATUS : rand_word());
      else
        send(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), rand_word());
    end
    if ($urandom_range(0, 1) == 0) read_data_run($urandom_range(1, 3));
  endtask

  task random_phase(input int n_items);
    int start;
    int pick;
    start = item_count;
    while (item_count - start < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) ident_sequence();
      else if (pick < 7) page_sequence();
      else noise_sequence();
    end
  endtask

  initial begin
    logic [1:0] rom_seq[5];
    rom_seq = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd2};
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    acc_valid = 1'b0;
    acc = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    cfg_write(2'd0);
    send(OP_READ, REG_CONTROL, 16'hFFFF);
    send(OP_WRITE, REG_CONTROL, 16'hFFFF);
    send(OP_READ, REG_CONTROL, 16'h0000);
    send(OP_WRITE, REG_CONTROL, 16'h0000);
    send(OP_WRITE, REG_COMMAND, CMD_IDENT);
    read_data_run(4);
    send(OP_WRITE, REG_ADDR_LOW, 16'hFFFF);
    send(OP_WRITE, REG_ADDR_HIGH, 16'hFFFF);
    send(OP_WRITE, REG_COMMAND, CMD_READ0);
    send(OP_READ, REG_DATA, 16'h0000);
    send(OP_WRITE, REG_TYPE, 16'hFFF0 | TYPE_SHIFT4);
    send(OP_READ, REG_DATA, 16'h0000);
    send(OP_WRITE, REG_COMMAND, CMD_READ1);
    send(OP_WRITE, REG_TYPE, {12'h000, TYPE_SHIFT5});
    send(OP_READ, REG_DATA, 16'h0000);
    send(OP_WRITE, REG_COMMAND, CMD_READ_SPARE);
    send(OP_WRITE, REG_CONTROL, 16'h4000);
    send(OP_WRITE, REG_ADDR_HIGH, 16'h8000);
    send(OP_READ, REG_DATA, 16'h0000);
    send(OP_WRITE, REG_COMMAND, CMD_STATUS);
    send(OP_READ, REG_DATA, 16'h0000);
    send(OP_READ, REG_ECC_LO, 16'h0000);
    send(OP_READ, REG_ECC_HI, 16'h0000);
    send(OP_READ, REG_DMA_CTRL, 16'h0000);
    send(OP_READ, REG_COMMAND, 16'h0000);
    send(OP_WRITE, REG_DATA, 16'h1234);
    send(OP_WRITE, REG_ECC_HI, 16'hFFFF);
    wait_drained();

    foreach (rom_seq[i]) begin
      cfg_write(rom_seq[i]);
      if (i == 1) begin
        // receiver holds off while a long burst keeps coming
        @(posedge clk);
        hold_request = 1'b1;
        burst_left = 100;
      end
      random_phase(PHASE_ITEMS);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    sb.check_leftover();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/nfc_pkg.sv
sv/nfc_cfg.sv
sv/nfc_addr.sv
sv/nfc_core.sv
sv/nand_flash_controller_regs.sv
test/testbench.sv
